>>> hw/rtl/qia_pkg.sv
// ----------------------------------------------------------------------------
// qia_pkg: shared types and constants of the quadratic integer ALU
// Payload structs, operation codes and the stage word carried by the
// divider cells.
// ----------------------------------------------------------------------------
package qia_pkg;

	localparam int OP_W     = 16;   // width of every operand field
	localparam int PROD_W   = 2 * OP_W;
	localparam int RAD_W    = 12;
	localparam int OUT_W    = 48;
	localparam int DIV_W    = 44;   // magnitude width of numerators and norm
	localparam int FRONT_ST = 4;    // stages ahead of the divider chain
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam logic [RAD_W-1:0] RADICAND_RST = RAD_W'(2);

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_NEG   = 4'd2,
		OP_SMUL  = 4'd3,
		OP_RMUL  = 4'd4,
		OP_NORM  = 4'd5,
		OP_CONJ  = 4'd6,
		OP_TPOS  = 4'd7,
		OP_DVBL  = 4'd8,
		OP_DIV   = 4'd9,
		OP_AREA  = 4'd10
	} opcode_t;

	typedef struct packed {
		logic [3:0]             operation;
		logic signed [OP_W-1:0] left_rational;
		logic signed [OP_W-1:0] left_irrational;
		logic signed [OP_W-1:0] right_rational;
		logic signed [OP_W-1:0] right_irrational;
		logic signed [OP_W-1:0] scalar;
	} op_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] out_rational;
		logic signed [OUT_W-1:0] out_irrational;
		logic                    predicate;
		logic                    divide_error;
	} res_t;

	// word handed from cell to cell
	typedef struct packed {
		logic [3:0]              op;
		logic                    div_zero;
		logic                    neg_r;
		logic                    neg_i;
		logic [DIV_W-1:0]        dvs;
		logic [DIV_W-1:0]        rem_r;
		logic [DIV_W-1:0]        rem_i;
		logic [DIV_W-1:0]        quo_r;   // dividend bits shift out, quotient in
		logic [DIV_W-1:0]        quo_i;
		logic signed [OUT_W-1:0] xr;
		logic signed [OUT_W-1:0] xi;
		logic                    pred;
	} cell_t;

endpackage

>>> hw/rtl/qia_front.sv
// ----------------------------------------------------------------------------
// qia_front: operand products and combination
// Four stages: operand capture, 16x16 products, radicand products, sums.
// ----------------------------------------------------------------------------
module qia_front #(
	parameter int OPERAND_WIDTH = qia_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic [qia_pkg::FRONT_ST-1:0]  en,
	input  qia_pkg::op_t                  din,
	input  logic [qia_pkg::RAD_W-1:0]     radicand,
	output qia_pkg::cell_t                dout
);
	import qia_pkg::*;

	localparam int EW = (OPERAND_WIDTH > OP_W) ? OP_W : OPERAND_WIDTH;
	localparam int SH = OP_W - EW;
	localparam int NP_W = PROD_W + RAD_W + 1;

	function automatic logic signed [OP_W-1:0] sx(input logic [OP_W-1:0] v);
		logic signed [OP_W-1:0] t;
		t = $signed(v << SH);
		return t >>> SH;
	endfunction

	// stage 1
	logic [3:0]             op_s1;
	logic signed [OP_W-1:0] lr_s1, li_s1, rr_s1, ri_s1, sc_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1 <= din.operation;
			lr_s1 <= sx(din.left_rational);
			li_s1 <= sx(din.left_irrational);
			rr_s1 <= sx(din.right_rational);
			ri_s1 <= sx(din.right_irrational);
			sc_s1 <= sx(din.scalar);
		end
	end

	// stage 2: products
	logic [3:0]               op_s2;
	logic signed [OP_W-1:0]   lr_s2, li_s2, rr_s2, ri_s2;
	logic signed [PROD_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_dd_s2, p_ee_s2;
	logic signed [PROD_W-1:0] p_ll_s2, p_mm_s2, p_sr_s2, p_si_s2, p_a_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s2   <= op_s1;
			lr_s2   <= lr_s1;
			li_s2   <= li_s1;
			rr_s2   <= rr_s1;
			ri_s2   <= ri_s1;
			p_rr_s2 <= lr_s1 * rr_s1;
			p_ii_s2 <= li_s1 * ri_s1;
			p_ri_s2 <= lr_s1 * ri_s1;
			p_ir_s2 <= li_s1 * rr_s1;
			p_dd_s2 <= rr_s1 * rr_s1;
			p_ee_s2 <= ri_s1 * ri_s1;
			p_ll_s2 <= lr_s1 * lr_s1;
			p_mm_s2 <= li_s1 * li_s1;
			p_sr_s2 <= lr_s1 * sc_s1;
			p_si_s2 <= li_s1 * sc_s1;
			p_a_s2  <= lr_s1 * li_s1;
		end
	end

	// stage 3: radicand products
	logic signed [RAD_W:0]    n_sg;
	logic [3:0]               op_s3;
	logic signed [OP_W-1:0]   lr_s3, li_s3, rr_s3, ri_s3;
	logic signed [PROD_W-1:0] p_rr_s3, p_ri_s3, p_ir_s3, p_dd_s3;
	logic signed [PROD_W-1:0] p_ll_s3, p_sr_s3, p_si_s3, p_a_s3;
	logic signed [NP_W-1:0]   n_ii_s3, n_ee_s3, n_mm_s3;

	assign n_sg = $signed({1'b0, radicand});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			op_s3   <= op_s2;
			lr_s3   <= lr_s2;
			li_s3   <= li_s2;
			rr_s3   <= rr_s2;
			ri_s3   <= ri_s2;
			p_rr_s3 <= p_rr_s2;
			p_ri_s3 <= p_ri_s2;
			p_ir_s3 <= p_ir_s2;
			p_dd_s3 <= p_dd_s2;
			p_ll_s3 <= p_ll_s2;
			p_sr_s3 <= p_sr_s2;
			p_si_s3 <= p_si_s2;
			p_a_s3  <= p_a_s2;
			n_ii_s3 <= NP_W'(n_sg) * NP_W'(p_ii_s2);
			n_ee_s3 <= NP_W'(n_sg) * NP_W'(p_ee_s2);
			n_mm_s3 <= NP_W'(n_sg) * NP_W'(p_mm_s2);
		end
	end

	// stage 4: sums and selection
	logic signed [OUT_W-1:0] w_lr, w_li, w_rr, w_ri;
	logic signed [OUT_W-1:0] w_rr_p, w_ri_p, w_ir_p, w_dd, w_ll, w_sr, w_si, w_a;
	logic signed [OUT_W-1:0] w_nii, w_nee, w_nmm;
	logic signed [OUT_W-1:0] nr, ni, dn, nrm, a_abs;
	cell_t                   c_d;
	cell_t                   c_s4;

	always_comb begin
		w_lr   = OUT_W'(lr_s3);
		w_li   = OUT_W'(li_s3);
		w_rr   = OUT_W'(rr_s3);
		w_ri   = OUT_W'(ri_s3);
		w_rr_p = OUT_W'(p_rr_s3);
		w_ri_p = OUT_W'(p_ri_s3);
		w_ir_p = OUT_W'(p_ir_s3);
		w_dd   = OUT_W'(p_dd_s3);
		w_ll   = OUT_W'(p_ll_s3);
		w_sr   = OUT_W'(p_sr_s3);
		w_si   = OUT_W'(p_si_s3);
		w_a    = OUT_W'(p_a_s3);
		w_nii  = OUT_W'(n_ii_s3);
		w_nee  = OUT_W'(n_ee_s3);
		w_nmm  = OUT_W'(n_mm_s3);

		nr    = w_rr_p - w_nii;
		ni    = w_ir_p - w_ri_p;
		dn    = w_dd - w_nee;
		nrm   = w_ll - w_nmm;
		a_abs = w_a[OUT_W-1] ? -w_a : w_a;

		c_d          = '0;
		c_d.op       = op_s3;
		c_d.div_zero = (dn == '0);
		c_d.neg_r    = nr[OUT_W-1] ^ dn[OUT_W-1];
		c_d.neg_i    = ni[OUT_W-1] ^ dn[OUT_W-1];
		c_d.dvs      = DIV_W'(dn[OUT_W-1] ? -dn : dn);
		c_d.quo_r    = DIV_W'(nr[OUT_W-1] ? -nr : nr);
		c_d.quo_i    = DIV_W'(ni[OUT_W-1] ? -ni : ni);

		case (op_s3)
			OP_ADD: begin
				c_d.xr = w_lr + w_rr;
				c_d.xi = w_li + w_ri;
			end
			OP_SUB: begin
				c_d.xr = w_lr - w_rr;
				c_d.xi = w_li - w_ri;
			end
			OP_NEG: begin
				c_d.xr = -w_lr;
				c_d.xi = -w_li;
			end
			OP_SMUL: begin
				c_d.xr = w_sr;
				c_d.xi = w_si;
			end
			OP_RMUL: begin
				c_d.xr = w_rr_p + w_nii;
				c_d.xi = w_ri_p + w_ir_p;
			end
			OP_NORM: c_d.xr = nrm;
			OP_CONJ: begin
				c_d.xr = w_lr;
				c_d.xi = -w_li;
			end
			OP_TPOS: c_d.pred = (w_lr > 0) && (nrm > 0);
			OP_AREA: c_d.xr = a_abs;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			c_s4 <= c_d;
		end
	end

	assign dout = c_s4;

endmodule

>>> hw/rtl/qia_cell.sv
// ----------------------------------------------------------------------------
// qia_cell: one restoring division step
// Develops one quotient bit of both the rational and irrational parts.
// ----------------------------------------------------------------------------
module qia_cell (
	input  logic           clk,
	input  logic           en,
	input  qia_pkg::cell_t d,
	output qia_pkg::cell_t q
);
	import qia_pkg::*;

	logic [DIV_W-1:0] sh_r, sh_i;
	logic [DIV_W:0]   df_r, df_i;
	cell_t            nx;
	cell_t            c_q;

	always_comb begin
		// remainder stays below the divisor, so the top bit is free to shift
		sh_r = {d.rem_r[DIV_W-2:0], d.quo_r[DIV_W-1]};
		sh_i = {d.rem_i[DIV_W-2:0], d.quo_i[DIV_W-1]};
		df_r = {1'b0, sh_r} - {1'b0, d.dvs};
		df_i = {1'b0, sh_i} - {1'b0, d.dvs};
		nx       = d;
		nx.rem_r = df_r[DIV_W] ? sh_r : df_r[DIV_W-1:0];
		nx.rem_i = df_i[DIV_W] ? sh_i : df_i[DIV_W-1:0];
		nx.quo_r = {d.quo_r[DIV_W-2:0], ~df_r[DIV_W]};
		nx.quo_i = {d.quo_i[DIV_W-2:0], ~df_i[DIV_W]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= nx;
		end
	end

	assign q = c_q;

endmodule

>>> hw/rtl/quadratic_integer_alu_top.sv
// ----------------------------------------------------------------------------
// quadratic_integer_alu_top: arithmetic on integers a + b*sqrt(N)
// Operation channel in, result channel out, radicand write channel.
// ----------------------------------------------------------------------------
// Usage:
//   op_*  : one operation per transfer (opcode, two operands, scalar).
//   res_* : one result per operation, in order.
//   cfg_* : writes the 12-bit radicand N; always ready. Write only while idle.
// Path: an op transfer passes through 4 front stages
//   (capture, products, radicand products, sums), one cell per quotient bit
//   of the 44-bit restoring divider, and the output register; the capture
//   stage loads at the transfer edge itself.
// Throughput: one operation per cycle while the result side does not stall. Every operation runs the full chain.
// Stall: each stage holds only while the stage after it is full and held,
//   so empty slots close up and op_ready stays high until the whole
//   pipeline is full behind a stalled result.
// Reset: all stages empty, N = 2.
// ----------------------------------------------------------------------------
module quadratic_integer_alu_top #(
	parameter int OPERAND_WIDTH = qia_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      op_valid,
	output logic                      op_ready,
	input  qia_pkg::op_t              op_data,
	output logic                      res_valid,
	input  logic                      res_ready,
	output qia_pkg::res_t             res_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [qia_pkg::RAD_W-1:0] cfg_data
);
	import qia_pkg::*;

	localparam int NST = FRONT_ST + DIV_W;

	logic [RAD_W-1:0] radicand_q;
	logic [NST-1:0]   vld_q;
	logic [NST:0]     move;
	logic             res_valid_q;
	res_t             res_q;
	res_t             res_d;
	cell_t            chain [DIV_W+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radicand_q <= RADICAND_RST;
		end else if (cfg_valid) begin
			radicand_q <= cfg_data;
		end
	end

	// a stage moves when empty or when its successor moves
	always_comb begin
		move[NST] = !res_valid_q || res_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			move[k] = !vld_q[k] || move[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (move[0]) begin
				vld_q[0] <= op_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (move[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (move[NST]) begin
				res_valid_q <= vld_q[NST-1];
			end
		end
	end

	qia_front #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_front (
		.clk      (clk),
		.en       (move[FRONT_ST-1:0]),
		.din      (op_data),
		.radicand (radicand_q),
		.dout     (chain[0])
	);

	for (genvar g = 0; g < DIV_W; g++) begin : g_cell
		qia_cell u_cell (
			.clk (clk),
			.en  (move[FRONT_ST+g]),
			.d   (chain[g]),
			.q   (chain[g+1])
		);
	end

	// result formatting
	always_comb begin
		res_d                = '0;
		res_d.out_rational   = chain[DIV_W].xr;
		res_d.out_irrational = chain[DIV_W].xi;
		res_d.predicate      = chain[DIV_W].pred;
		if (chain[DIV_W].op == OP_DVBL || chain[DIV_W].op == OP_DIV) begin
			res_d = '0;
			if (chain[DIV_W].div_zero) begin
				res_d.divide_error = 1'b1;
			end else if (chain[DIV_W].rem_r == '0 && chain[DIV_W].rem_i == '0) begin
				res_d.predicate = 1'b1;
				if (chain[DIV_W].op == OP_DIV) begin
					res_d.out_rational = chain[DIV_W].neg_r
						? -OUT_W'(chain[DIV_W].quo_r) : OUT_W'(chain[DIV_W].quo_r);
					res_d.out_irrational = chain[DIV_W].neg_i
						? -OUT_W'(chain[DIV_W].quo_i) : OUT_W'(chain[DIV_W].quo_i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move[NST]) begin
			res_q <= res_d;
		end
	end

	assign op_ready  = move[0];
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

>>> hw/rtl/qia_checker.sv
// ----------------------------------------------------------------------------
// qia_checker: port-level checks of the quadratic integer ALU
// Watches the top level's channels over time.
// ----------------------------------------------------------------------------
module qia_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      op_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input qia_pkg::res_t             res_data,
	input logic                      cfg_ready
);

	// a held result does not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// a divide error carries no quotient and no predicate
	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.divide_error |->
			!res_data.predicate && res_data.out_rational == '0 &&
			res_data.out_irrational == '0)
		else $error("divide error with nonzero result");

	// input backpressure only comes from a stalled, full pipeline
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!op_ready |-> res_valid && !res_ready)
		else $error("op_ready low without a stalled result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready dropped");

endmodule

bind quadratic_integer_alu_top qia_checker u_qia_checker (.*);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the quadratic integer ALU
// A directed table walks every operation, operand extremes, zero and
// inexact division and unused codes. Random operations follow under several
// radicands. Every result is checked against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import qia_pkg::*;

	localparam int LATENCY   = 48;
	localparam int WDOG_MAX  = 20000;
	localparam int RAND_OPS  = 1400;

	typedef struct packed {
		op_t  op;
		logic chk;   // typed-in expectation present
		res_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_ready;
	op_t  op_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RAD_W-1:0] cfg_data = '0;

	logic [RAD_W-1:0] radicand_q = RADICAND_RST;
	res_t pending_res[$];
	int   err_cnt = 0;
	int   wdog = 0;

	quadratic_integer_alu_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_ready(op_ready), .op_data(op_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic res_t alu_predict(op_t o, logic [RAD_W-1:0] rad);
		longint lr, li, rr, ri, sc, n, d, nr, ni, s;
		res_t r;
		lr = o.left_rational; li = o.left_irrational;
		rr = o.right_rational; ri = o.right_irrational;
		sc = o.scalar; n = rad;
		r = '0;
		case (o.operation)
			OP_ADD: begin
				r.out_rational = OUT_W'(lr + rr);
				r.out_irrational = OUT_W'(li + ri);
			end
			OP_SUB: begin
				r.out_rational = OUT_W'(lr - rr);
				r.out_irrational = OUT_W'(li - ri);
			end
			OP_NEG: begin
				r.out_rational = OUT_W'(-lr);
				r.out_irrational = OUT_W'(-li);
			end
			OP_SMUL: begin
				r.out_rational = OUT_W'(lr * sc);
				r.out_irrational = OUT_W'(li * sc);
			end
			OP_RMUL: begin
				r.out_rational = OUT_W'(lr * rr + n * li * ri);
				r.out_irrational = OUT_W'(lr * ri + li * rr);
			end
			OP_NORM: r.out_rational = OUT_W'(lr * lr - n * li * li);
			OP_CONJ: begin
				r.out_rational = OUT_W'(lr);
				r.out_irrational = OUT_W'(-li);
			end
			OP_TPOS: r.predicate = (lr > 0 && lr * lr - n * li * li > 0);
			OP_DVBL, OP_DIV: begin
				d  = rr * rr - n * ri * ri;
				nr = lr * rr - n * li * ri;
				ni = li * rr - lr * ri;
				if (d == 0)
					r.divide_error = 1'b1;
				else if (nr % d == 0 && ni % d == 0) begin
					r.predicate = 1'b1;
					if (o.operation == OP_DIV) begin
						r.out_rational = OUT_W'(nr / d);
						r.out_irrational = OUT_W'(ni / d);
					end
				end
			end
			OP_AREA: begin
				s = lr * li;
				r.out_rational = OUT_W'((s < 0) ? -s : s);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	// result side: random stalls, compare each transfer with the oldest entry
	initial begin
		int gap;
		res_t want;
		@(posedge clk iff arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk iff res_valid);
			if (pending_res.size() == 0) begin
				report("result transfer with nothing pending", 1, 0);
			end else begin
				want = pending_res.pop_front();
				if (res_data.out_rational !== want.out_rational)
					report("out_rational", res_data.out_rational, want.out_rational);
				if (res_data.out_irrational !== want.out_irrational)
					report("out_irrational", res_data.out_irrational, want.out_irrational);
				if (res_data.predicate !== want.predicate)
					report("predicate", res_data.predicate, want.predicate);
				if (res_data.divide_error !== want.divide_error)
					report("divide_error", res_data.divide_error, want.divide_error);
			end
		end
	end

	always @(posedge clk) begin
		if ((op_valid && op_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_op(op_t o, logic chk, res_t typed);
		int gap;
		res_t p;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p = alu_predict(o, radicand_q);
		if (chk && p !== typed)
			report("table row against predictor", 1, 0);
		pending_res.push_back(p);
		op_valid <= 1'b1;
		op_data  <= o;
		@(posedge clk iff op_ready);
	endtask

	task automatic drain_and_write(logic [RAD_W-1:0] rad);
		op_valid <= 1'b0;
		@(posedge clk);
		wait (pending_res.size() == 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= rad;
		@(posedge clk iff cfg_ready);
		cfg_valid <= 1'b0;
		radicand_q = rad;
	endtask

	function automatic op_t rand_op(bit wide);
		op_t o;
		o.operation = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
			: 4'($urandom_range(0, 10));
		o.left_rational    = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 40)) - 20);
		o.left_irrational  = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 40)) - 20);
		o.right_rational   = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 10)) - 5);
		o.right_irrational = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 6)) - 3);
		o.scalar = 16'($urandom);
		return o;
	endfunction

	// build an exact quotient: L = Q * R, exact unless L wraps to 16 bits or R has zero norm
	function automatic op_t exact_div_op();
		op_t o;
		longint qr, qi, rr, ri, n;
		n  = radicand_q;
		qr = $signed($urandom_range(0, 200)) - 100;
		qi = $signed($urandom_range(0, 20)) - 10;
		rr = $signed($urandom_range(0, 40)) - 20;
		ri = $signed($urandom_range(0, 6)) - 3;
		o.operation = $urandom_range(0, 1) ? OP_DIV : OP_DVBL;
		o.left_rational = 16'(qr * rr + n * qi * ri);
		o.left_irrational = 16'(qr * ri + qi * rr);
		o.right_rational = 16'(rr);
		o.right_irrational = 16'(ri);
		o.scalar = 16'($urandom);
		return o;
	endfunction

	row_t dir_tab[$];
	logic [RAD_W-1:0] rad_set[6] = '{12'd2, 12'd4095, 12'd0, 12'd1, 12'd5, 12'd3};

	function automatic row_t mk(opcode_t opc, int lr, int li, int rr, int ri, int sc,
			logic chk, longint er, longint ei, logic pr, logic de);
		row_t t;
		t.op = '{opc, 16'(lr), 16'(li), 16'(rr), 16'(ri), 16'(sc)};
		t.chk = chk;
		t.res = '{48'(er), 48'(ei), pr, de};
		return t;
	endfunction

	initial begin
		row_t t;
		op_t o;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// radicand 2 after reset
		dir_tab.push_back(mk(OP_ADD, 32767, 32767, 32767, 32767, 0, 1, 65534, 65534, 0, 0));
		dir_tab.push_back(mk(OP_SUB, -32768, -32768, 32767, 32767, 0, 1, -65535, -65535, 0, 0));
		dir_tab.push_back(mk(OP_NEG, -32768, 32767, 0, 0, 0, 1, 32768, -32767, 0, 0));
		dir_tab.push_back(mk(OP_SMUL, -32768, 32767, 0, 0, -32768, 1,
			1073741824, -1073709056, 0, 0));
		dir_tab.push_back(mk(OP_RMUL, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_NORM, 3, 2, 0, 0, 0, 1, 1, 0, 0, 0));
		dir_tab.push_back(mk(OP_NORM, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_CONJ, -32768, -32768, 0, 0, 0, 1, -32768, 32768, 0, 0));
		dir_tab.push_back(mk(OP_TPOS, 3, 2, 0, 0, 0, 1, 0, 0, 1, 0));
		dir_tab.push_back(mk(OP_TPOS, 1, 1, 0, 0, 0, 1, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_TPOS, -3, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_DVBL, 5, 7, 0, 0, 0, 1, 0, 0, 0, 1));
		dir_tab.push_back(mk(OP_DIV, 5, 7, 0, 0, 0, 1, 0, 0, 0, 1));
		dir_tab.push_back(mk(OP_DIV, 6, 3, 3, 0, 0, 1, 2, 1, 1, 0));
		dir_tab.push_back(mk(OP_DIV, 7, 4, 3, 0, 0, 1, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_DVBL, 7, 4, 3, 0, 0, 1, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_DIV, -32768, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_DIV, 1, 1, 3, 2, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(OP_AREA, -32768, 32767, 0, 0, 0, 1, 1073709056, 0, 0, 0));
		dir_tab.push_back(mk(OP_AREA, -32768, -32768, 0, 0, 0, 1, 1073741824, 0, 0, 0));
		t = mk(OP_ADD, 1, 2, 3, 4, 5, 1, 0, 0, 0, 0);
		t.op.operation = 4'd15;
		dir_tab.push_back(t);
		t.op.operation = 4'd11;
		dir_tab.push_back(t);
		foreach (dir_tab[k])
			send_op(dir_tab[k].op, dir_tab[k].chk, dir_tab[k].res);

		// radicand 4 makes zero-norm divisors from squares
		drain_and_write(12'd4);
		send_op('{OP_DVBL, 16'sd3, 16'sd1, 16'sd2, 16'sd1, 16'sd0}, 1'b1, '{0, 0, 0, 1});
		send_op('{OP_DIV, 16'sd3, 16'sd1, -16'sd4, 16'sd2, 16'sd0}, 1'b1, '{0, 0, 0, 1});

		foreach (rad_set[s]) begin
			drain_and_write(rad_set[s]);
			for (int k = 0; k < RAND_OPS / 6; k++) begin
				case ($urandom_range(0, 3))
					0: o = exact_div_op();
					1: o = rand_op(1'b0);
					default: o = rand_op(1'b1);
				endcase
				send_op(o, 1'b0, '0);
			end
		end
		op_valid <= 1'b0;
		@(posedge clk);
		wait (pending_res.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
